>>> src/tcw_pkg.sv
// shared types, constants and helpers for the text console writer
package tcw_pkg;

    localparam int WIDTH  = 80;
    localparam int HEIGHT = 25;
    localparam int CELLS  = WIDTH * HEIGHT;

    localparam int ADDR_W = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;

    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] ATTR_RST = 8'h0F;

    localparam logic [ADDR_W-1:0] CELLS_A  = ADDR_W'(CELLS);
    localparam logic [ADDR_W-1:0] WIDTH_A  = ADDR_W'(WIDTH);
    localparam logic [ADDR_W-1:0] SCROLL_A = ADDR_W'(CELLS - WIDTH);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(WIDTH - 1);
    localparam logic [ROW_W-1:0]  HEIGHT_R = ROW_W'(HEIGHT);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(HEIGHT - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic              accept;
        logic              clear_wr;
        logic              scroll_step;
        logic              exec;
        logic [ADDR_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic scroll_req;
    } t_sts;

    function automatic logic [ADDR_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] prod;
        prod = ADDR_W'(row) * WIDTH_A;
        return prod + ADDR_W'(col);
    endfunction

endpackage

>>> src/text_console_writer.sv
// text console writer top level: 80x25 screen store with cursor
// a result word is registered by the write step, after its input word is latched and any scroll sweep has run
// a new input word is taken only once the previous result word is registered; writes share one memory write port
// a character that scrolls first runs a row copy sweep that moves every row up and blanks the last row
// reset: synchronous; a clearing pass then zeroes every screen cell, input held off
// the attribute register is writable at all times and resets to 0x0f
module text_console_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // character[7:0], update_cursor[8], zero fill
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // cell_written[0], cell_index[11:1], cell_value[27:12], scrolled[28],
    // column[35:29], row[40:36], cursor_pos[51:41], cursor_update[52], zero fill
    output logic [55:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    tcw_pkg::t_cmd cmd;
    tcw_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

>>> src/tcw_ctrl.sv
// controller: clearing pass, scroll sequencing and item handshake
module tcw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  tcw_pkg::t_sts i_sts,
    output tcw_pkg::t_cmd o_cmd
);

    tcw_pkg::t_state r_state, n_state;
    logic [tcw_pkg::ADDR_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic slot_free;

    assign slot_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::ST_CLEAR: begin
                if (r_cnt == tcw_pkg::CELLS_A - 1'b1) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = i_sts.scroll_req ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_SCROLL: begin
                if (r_cnt == tcw_pkg::CELLS_A) begin
                    n_state = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                if (slot_free) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.cnt   = r_cnt;
        o_s_tready  = 1'b0;
        n_cnt       = r_cnt;
        case (r_state)
            tcw_pkg::ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                n_cnt = (r_cnt == tcw_pkg::CELLS_A - 1'b1) ? '0 : r_cnt + 1'b1;
            end
            tcw_pkg::ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                n_cnt        = '0;
            end
            tcw_pkg::ST_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                n_cnt = (r_cnt == tcw_pkg::CELLS_A) ? '0 : r_cnt + 1'b1;
            end
            tcw_pkg::ST_EXEC: begin
                o_cmd.exec = slot_free;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

`ifndef SYNTHESIS
    a_scroll_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_SCROLL && r_cnt == tcw_pkg::CELLS_A)
        |=> (r_state == tcw_pkg::ST_EXEC))
        else $error("scroll sweep did not hand over to the write step");
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready)
        |=> (r_state == tcw_pkg::ST_SCROLL || r_state == tcw_pkg::ST_EXEC))
        else $error("accepted word not processed");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tcw_pkg::CELLS_A)
        else $error("sweep counter out of range");
`endif

endmodule

>>> src/tcw_dp.sv
// datapath: screen memory, cursor, attribute and result register
module tcw_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_s_tdata,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_data,
    input  tcw_pkg::t_cmd i_cmd,
    output tcw_pkg::t_sts o_sts,
    output logic [55:0]   o_m_tdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

    logic [7:0]                 r_attr;
    logic [tcw_pkg::COL_W-1:0]  r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0]  r_row, n_row;
    logic [7:0]                 r_char;
    logic                       r_upd;
    logic                       r_scr;

    logic                       r_pend;
    logic                       r_fill;
    logic [tcw_pkg::ADDR_W-1:0] r_pend_addr;
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;

    logic                       we;
    logic [tcw_pkg::ADDR_W-1:0] wa;
    logic [tcw_pkg::CELL_W-1:0] wd;
    logic                       rd_en;
    logic [tcw_pkg::ADDR_W-1:0] rd_addr;

    logic [tcw_pkg::COL_W-1:0]  b_col;
    logic [tcw_pkg::ROW_W-1:0]  b_row;
    logic                       is_nl;
    logic [tcw_pkg::ADDR_W-1:0] idx;
    logic [tcw_pkg::ADDR_W-1:0] pos;
    logic [tcw_pkg::CELL_W-1:0] val;

    logic                       r_o_written;
    logic [tcw_pkg::ADDR_W-1:0] r_o_idx;
    logic [tcw_pkg::CELL_W-1:0] r_o_val;
    logic                       r_o_scr;
    logic [tcw_pkg::COL_W-1:0]  r_o_col;
    logic [tcw_pkg::ROW_W-1:0]  r_o_row;
    logic [tcw_pkg::ADDR_W-1:0] r_o_pos;
    logic                       r_o_upd;

    assign o_sts.scroll_req = (i_s_tdata[7:0] != tcw_pkg::CHAR_NL) && (r_row >= tcw_pkg::HEIGHT_R);

    // cursor step for the latched character
    always_comb begin
        b_col = r_scr ? '0 : r_col;
        b_row = r_scr ? tcw_pkg::LAST_ROW : r_row;
        is_nl = (r_char == tcw_pkg::CHAR_NL);
        idx   = tcw_pkg::lin_pos(b_row, b_col);
        val   = {r_attr, r_char};
        if (is_nl) begin
            n_col = '0;
            n_row = (r_row < tcw_pkg::HEIGHT_R) ? r_row + 1'b1 : r_row;
        end else if (b_col < tcw_pkg::LAST_COL) begin
            n_col = b_col + 1'b1;
            n_row = b_row;
        end else begin
            n_col = '0;
            n_row = b_row + 1'b1;
        end
        pos = tcw_pkg::lin_pos(n_row, n_col);
    end

    // single write port shared by clearing, scroll copy and character write
    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (i_cmd.clear_wr) begin
            we = 1'b1;
            wa = i_cmd.cnt;
        end else if (r_pend) begin
            we = 1'b1;
            wa = r_pend_addr;
            wd = r_fill ? {r_attr, tcw_pkg::CHAR_SP} : r_rd_data;
        end else if (i_cmd.exec && !is_nl && idx < tcw_pkg::CELLS_A) begin
            we = 1'b1;
            wa = idx;
            wd = val;
        end
    end

    assign rd_en   = i_cmd.scroll_step && (i_cmd.cnt < tcw_pkg::SCROLL_A);
    assign rd_addr = i_cmd.cnt + tcw_pkg::WIDTH_A;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RST;
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_pend <= i_cmd.scroll_step && (i_cmd.cnt < tcw_pkg::CELLS_A);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= i_cmd.cnt;
        r_fill      <= (i_cmd.cnt >= tcw_pkg::SCROLL_A);
        if (i_cmd.accept) begin
            r_char <= i_s_tdata[7:0];
            r_upd  <= i_s_tdata[8];
            r_scr  <= o_sts.scroll_req;
        end
        if (i_cmd.exec) begin
            r_o_written <= !is_nl;
            r_o_idx     <= is_nl ? '0 : idx;
            r_o_val     <= is_nl ? '0 : val;
            r_o_scr     <= r_scr;
            r_o_col     <= n_col;
            r_o_row     <= n_row;
            r_o_pos     <= r_upd ? pos : '0;
            r_o_upd     <= r_upd;
        end
    end

    assign o_m_tdata = {3'b000, r_o_upd, r_o_pos, r_o_row, r_o_col, r_o_scr,
                        r_o_val, r_o_idx, r_o_written};

`ifndef SYNTHESIS
    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && i_cmd.exec))
        else $error("scroll copy write collides with character write");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= tcw_pkg::HEIGHT_R)
        else $error("cursor row out of range");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_col <= tcw_pkg::LAST_COL))
        else $error("cursor column out of range");
`endif

endmodule
